@@ sv/grid_aggregation_walker_unit_macros.svh @@
// assertion macros shared by the grid aggregation walker modules
// expects clk_i and rst_ni in the scope of each use
`ifndef GRID_AGGREGATION_WALKER_UNIT_MACROS_SVH
`define GRID_AGGREGATION_WALKER_UNIT_MACROS_SVH

// property must hold at every clock edge out of reset
`define GAW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define GAW_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

@@ sv/gaw_pkg.sv @@
// types, codes and defaults for the grid aggregation walker
// no dependencies
package gaw_pkg;

  // default grid storage size
  localparam int GRID_COLS_MAX_DEF = 64;
  localparam int GRID_ROWS_MAX_DEF = 64;

  // field widths
  localparam int COORD_W  = 6;
  localparam int DIM_W    = 7;
  localparam int CELL_W   = 3;
  localparam int STATUS_W = 3;
  localparam int PICK_W   = 2;
  localparam int ACTION_W = 2;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [DIM_W-1:0]   dim_t;
  typedef logic [CELL_W-1:0]  cell_t;

  // reset value of the grid size registers
  localparam dim_t DIM_RESET = 7'd64;

  // register select bit of paddr
  localparam int REG_SEL_BIT = 2;
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // cell codes
  localparam cell_t CELL_EMPTY = 3'd0;
  localparam cell_t CELL_UP    = 3'd1;
  localparam cell_t CELL_RIGHT = 3'd2;
  localparam cell_t CELL_DOWN  = 3'd3;
  localparam cell_t CELL_LEFT  = 3'd4;
  localparam cell_t CELL_ROOT  = 3'd5;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ROOT  = 2'd0,
    ACT_SPAWN = 2'd1,
    ACT_STEP  = 2'd2,
    ACT_READ  = 2'd3
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 3'd0,
    ST_REJECTED  = 3'd1,
    ST_MOVED     = 3'd2,
    ST_ATTACHED  = 3'd3,
    ST_NO_WALKER = 3'd4,
    ST_STUCK     = 3'd5,
    ST_RANGE     = 3'd6
  } status_e;

  // which cell a grid read addresses or a capture loads
  typedef enum logic [2:0] {
    NBR_CTR  = 3'd0,
    NBR_UP   = 3'd1,
    NBR_RT   = 3'd2,
    NBR_DN   = 3'd3,
    NBR_LF   = 3'd4,
    NBR_NONE = 3'd5
  } nbr_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic clr_wr;
    nbr_e rd_sel;
    nbr_e cap_sel;
    logic fin;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic is_step;
    logic out_free;
  } dp_stat_t;

endpackage

@@ sv/gaw_channels.sv @@
// valid/ready channel interfaces for the walker's action and result words
// depends on gaw_pkg
interface gaw_in_if;
  import gaw_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [COORD_W-1:0]  col;
  logic [COORD_W-1:0]  row;
  logic [PICK_W-1:0]   pick;

  modport source (output valid, action, col, row, pick, input ready);
  modport sink   (input valid, action, col, row, pick, output ready);
endinterface

interface gaw_out_if;
  import gaw_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [CELL_W-1:0]   cell_code;
  logic [COORD_W-1:0]  walker_col;
  logic [COORD_W-1:0]  walker_row;

  modport source (output valid, status, cell_code, walker_col, walker_row, input ready);
  modport sink   (input valid, status, cell_code, walker_col, walker_row, output ready);
endinterface

@@ sv/gaw_ram.sv @@
// generic single write port ram with registered read
// no dependencies
module gaw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/gaw_ctrl.sv @@
// sequencer for the walker: clearing pass, grid reads, finish
// depends on gaw_pkg and the assertion macro header
`include "grid_aggregation_walker_unit_macros.svh"

module gaw_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  gaw_pkg::dp_stat_t stat_i,
  output gaw_pkg::dp_cmd_t  cmd_o
);
  import gaw_pkg::*;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_RD_C  = 8'b0000_0100,
    S_RD_UP = 8'b0000_1000,
    S_RD_RT = 8'b0001_0000,
    S_RD_DN = 8'b0010_0000,
    S_RD_LF = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d       = state_q;
    in_ready_o    = 1'b0;
    cmd_o.load    = 1'b0;
    cmd_o.clr_wr  = 1'b0;
    cmd_o.rd_sel  = NBR_CTR;
    cmd_o.cap_sel = NBR_NONE;
    cmd_o.fin     = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_RD_C;
        end
      end
      S_RD_C: begin
        cmd_o.cap_sel = NBR_CTR;
        if (stat_i.is_step) begin
          cmd_o.rd_sel = NBR_UP;
          state_d      = S_RD_UP;
        end else begin
          state_d = S_FIN;
        end
      end
      S_RD_UP: begin
        cmd_o.cap_sel = NBR_UP;
        cmd_o.rd_sel  = NBR_RT;
        state_d       = S_RD_RT;
      end
      S_RD_RT: begin
        cmd_o.cap_sel = NBR_RT;
        cmd_o.rd_sel  = NBR_DN;
        state_d       = S_RD_DN;
      end
      S_RD_DN: begin
        cmd_o.cap_sel = NBR_DN;
        cmd_o.rd_sel  = NBR_LF;
        state_d       = S_RD_LF;
      end
      S_RD_LF: begin
        cmd_o.cap_sel = NBR_LF;
        state_d       = S_FIN;
      end
      S_FIN: begin
        // wait for room in the result register
        if (stat_i.out_free) begin
          cmd_o.fin = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  `GAW_ASSERT(a_accept_starts_read, (in_valid_i && in_ready_o) |=> (state_q == S_RD_C), "accepted word did not start a grid read")
  `GAW_NEVER(a_no_accept_in_clear, (state_q == S_CLEAR) && cmd_o.load, "word loaded during clearing pass")

endmodule

@@ sv/gaw_datapath.sv @@
// walker datapath: grid memory, walker registers, decision logic, result register
// depends on gaw_pkg, gaw_ram and the assertion macro header
`include "grid_aggregation_walker_unit_macros.svh"

module gaw_datapath #(
  parameter int GRID_COLS_MAX = gaw_pkg::GRID_COLS_MAX_DEF,
  parameter int GRID_ROWS_MAX = gaw_pkg::GRID_ROWS_MAX_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  gaw_pkg::dp_cmd_t              cmd_i,
  output gaw_pkg::dp_stat_t             stat_o,
  input  logic [gaw_pkg::ACTION_W-1:0]  in_action_i,
  input  gaw_pkg::coord_t               in_col_i,
  input  gaw_pkg::coord_t               in_row_i,
  input  logic [gaw_pkg::PICK_W-1:0]    in_pick_i,
  input  gaw_pkg::dim_t                 width_cfg_i,
  input  gaw_pkg::dim_t                 height_cfg_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [gaw_pkg::STATUS_W-1:0]  out_status_o,
  output gaw_pkg::cell_t                out_cell_o,
  output gaw_pkg::coord_t               out_wcol_o,
  output gaw_pkg::coord_t               out_wrow_o
);
  import gaw_pkg::*;

  localparam int DEPTH  = GRID_COLS_MAX * GRID_ROWS_MAX;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int LIM_W  = (GRID_COLS_MAX < 64) ? GRID_COLS_MAX : 64;
  localparam int LIM_H  = (GRID_ROWS_MAX < 64) ? GRID_ROWS_MAX : 64;

  typedef logic [ADDR_W-1:0] addr_t;

  function automatic addr_t cell_addr(input dim_t c, input dim_t r);
    cell_addr = ADDR_W'(r) * ADDR_W'(GRID_COLS_MAX) + ADDR_W'(c);
  endfunction

  // item and captured cells
  action_e act_q;
  coord_t  col_q, row_q;
  logic [PICK_W-1:0] pick_q;
  cell_t   ctr_q, up_q, rt_q, dn_q, lf_q;

  // walker and clearing counter
  coord_t wx_q, wy_q;
  logic   wact_q;
  addr_t  clr_q;

  // result register
  logic    out_valid_q;
  status_e out_status_q;
  cell_t   out_cell_q;
  coord_t  out_wcol_q, out_wrow_q;

  dim_t    eff_w, eff_h;
  coord_t  ld_col, ld_row, ctr_col, ctr_row;
  logic    up_ok, rt_ok, dn_ok, lf_ok, in_range;
  cell_t   up_v, rt_v, dn_v, lf_v;
  addr_t   ctr_addr, rd_addr, wr_addr;
  cell_t   rdata;
  logic    ram_we;
  cell_t   ram_wdata;

  logic [3:0] mv_ok;
  logic [2:0] mv_cnt;
  logic [1:0] mv_sel, mv_rank, mv_idx;
  logic       mv_found;

  status_e st_d;
  cell_t   code_d, wcode;
  coord_t  wx_d, wy_d;
  logic    wact_d, we_fin;

  // clamp grid size registers
  always_comb begin
    eff_w = width_cfg_i;
    if (width_cfg_i == '0) eff_w = 7'd1;
    else if (width_cfg_i > DIM_W'(LIM_W)) eff_w = DIM_W'(LIM_W);
    eff_h = height_cfg_i;
    if (height_cfg_i == '0) eff_h = 7'd1;
    else if (height_cfg_i > DIM_W'(LIM_H)) eff_h = DIM_W'(LIM_H);
  end

  // center cell: walker for a step, else the item coordinates
  assign ld_col  = (action_e'(in_action_i) == ACT_STEP) ? wx_q : in_col_i;
  assign ld_row  = (action_e'(in_action_i) == ACT_STEP) ? wy_q : in_row_i;
  assign ctr_col = cmd_i.load ? ld_col : col_q;
  assign ctr_row = cmd_i.load ? ld_row : row_q;

  // in-grid neighbours of the latched center
  assign up_ok    = (row_q != '0);
  assign lf_ok    = (col_q != '0);
  assign rt_ok    = ({1'b0, col_q} + 7'd1) < eff_w;
  assign dn_ok    = ({1'b0, row_q} + 7'd1) < eff_h;
  assign in_range = ({1'b0, col_q} < eff_w) && ({1'b0, row_q} < eff_h);

  // grid read address
  assign ctr_addr = cell_addr({1'b0, ctr_col}, {1'b0, ctr_row});
  always_comb begin
    rd_addr = ctr_addr;
    case (cmd_i.rd_sel)
      NBR_UP: if (up_ok) rd_addr = cell_addr({1'b0, col_q}, {1'b0, row_q} - 7'd1);
      NBR_RT: if (rt_ok) rd_addr = cell_addr({1'b0, col_q} + 7'd1, {1'b0, row_q});
      NBR_DN: if (dn_ok) rd_addr = cell_addr({1'b0, col_q}, {1'b0, row_q} + 7'd1);
      NBR_LF: if (lf_ok) rd_addr = cell_addr({1'b0, col_q} - 7'd1, {1'b0, row_q});
      default: rd_addr = ctr_addr;
    endcase
  end

  // grid write: clearing pass or finishing item
  assign ram_we    = cmd_i.clr_wr || (cmd_i.fin && we_fin);
  assign wr_addr   = cmd_i.clr_wr ? clr_q : cell_addr({1'b0, col_q}, {1'b0, row_q});
  assign ram_wdata = cmd_i.clr_wr ? CELL_EMPTY : wcode;

  gaw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (DEPTH)
  ) u_grid (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_addr),
    .wdata_i (ram_wdata),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  // item latch and cell captures
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q  <= action_e'(in_action_i);
      col_q  <= ld_col;
      row_q  <= ld_row;
      pick_q <= in_pick_i;
    end
    case (cmd_i.cap_sel)
      NBR_CTR: ctr_q <= rdata;
      NBR_UP:  up_q  <= rdata;
      NBR_RT:  rt_q  <= rdata;
      NBR_DN:  dn_q  <= rdata;
      NBR_LF:  lf_q  <= rdata;
      default: ;
    endcase
  end

  // neighbours outside the grid read as empty
  assign up_v = up_ok ? up_q : CELL_EMPTY;
  assign rt_v = rt_ok ? rt_q : CELL_EMPTY;
  assign dn_v = dn_ok ? dn_q : CELL_EMPTY;
  assign lf_v = lf_ok ? lf_q : CELL_EMPTY;

  // allowed moves in order down, right, up, left; pick reduced by count
  assign mv_ok  = {lf_ok, up_ok, rt_ok, dn_ok};
  assign mv_cnt = 3'($countones(mv_ok));
  always_comb begin
    case (mv_cnt)
      3'd2:    mv_sel = {1'b0, pick_q[0]};
      3'd3:    mv_sel = (pick_q == 2'd3) ? 2'd0 : pick_q;
      3'd4:    mv_sel = pick_q;
      default: mv_sel = 2'd0;
    endcase
    mv_rank  = 2'd0;
    mv_idx   = 2'd0;
    mv_found = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (mv_ok[i]) begin
        if (!mv_found && (mv_rank == mv_sel)) begin
          mv_idx   = 2'(i);
          mv_found = 1'b1;
        end
        mv_rank = mv_rank + 2'd1;
      end
    end
  end

  // outcome of the item
  always_comb begin
    st_d   = ST_DONE;
    code_d = CELL_EMPTY;
    wcode  = CELL_ROOT;
    we_fin = 1'b0;
    wx_d   = wx_q;
    wy_d   = wy_q;
    wact_d = wact_q;
    case (act_q)
      ACT_STEP: begin
        if (!wact_q) begin
          st_d = ST_NO_WALKER;
        end else if (!in_range) begin
          st_d   = ST_RANGE;
          wact_d = 1'b0;
        end else if (ctr_q != CELL_EMPTY) begin
          // cell taken under the walker: end without writing
          st_d   = ST_ATTACHED;
          code_d = ctr_q;
          wact_d = 1'b0;
        end else if ((up_v | rt_v | dn_v | lf_v) != CELL_EMPTY) begin
          st_d   = ST_ATTACHED;
          wcode  = (up_v != CELL_EMPTY) ? CELL_UP :
                   (rt_v != CELL_EMPTY) ? CELL_RIGHT :
                   (dn_v != CELL_EMPTY) ? CELL_DOWN : CELL_LEFT;
          code_d = wcode;
          we_fin = 1'b1;
          wact_d = 1'b0;
        end else if (mv_cnt == 3'd0) begin
          st_d   = ST_STUCK;
          wact_d = 1'b0;
        end else begin
          st_d = ST_MOVED;
          case (mv_idx)
            2'd0:    wy_d = wy_q + 6'd1;
            2'd1:    wx_d = wx_q + 6'd1;
            2'd2:    wy_d = wy_q - 6'd1;
            default: wx_d = wx_q - 6'd1;
          endcase
        end
      end
      ACT_ROOT: begin
        if (!in_range) begin
          st_d = ST_RANGE;
        end else begin
          code_d = CELL_ROOT;
          we_fin = 1'b1;
        end
      end
      ACT_SPAWN: begin
        if (!in_range) begin
          st_d = ST_RANGE;
        end else if (ctr_q != CELL_EMPTY) begin
          st_d   = ST_REJECTED;
          code_d = ctr_q;
        end else begin
          wx_d   = col_q;
          wy_d   = row_q;
          wact_d = 1'b1;
        end
      end
      ACT_READ: begin
        if (!in_range) begin
          st_d = ST_RANGE;
        end else begin
          code_d = ctr_q;
        end
      end
      default: st_d = ST_DONE;
    endcase
  end

  // walker, clearing counter and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wx_q        <= '0;
      wy_q        <= '0;
      wact_q      <= 1'b0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_wr) clr_q <= clr_q + addr_t'(1);
      if (cmd_i.fin) begin
        wx_q        <= wx_d;
        wy_q        <= wy_d;
        wact_q      <= wact_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result word
  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      out_status_q <= st_d;
      out_cell_q   <= code_d;
      out_wcol_q   <= wx_d;
      out_wrow_q   <= wy_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_cell_o   = out_cell_q;
  assign out_wcol_o   = out_wcol_q;
  assign out_wrow_o   = out_wrow_q;

  assign stat_o.clr_last = (clr_q == addr_t'(DEPTH - 1));
  assign stat_o.is_step  = (act_q == ACT_STEP);
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  `GAW_ASSERT(a_walker_in_limits, wact_q |-> (({1'b0, wx_q} < DIM_W'(LIM_W)) && ({1'b0, wy_q} < DIM_W'(LIM_H))), "active walker outside grid storage")
  `GAW_NEVER(a_result_overwrite, cmd_i.fin && out_valid_q && !out_ready_i, "result overwritten before taken")
  `GAW_NEVER(a_empty_write, cmd_i.fin && we_fin && (wcode == CELL_EMPTY), "item wrote an empty code")

endmodule

@@ sv/grid_aggregation_walker_unit.sv @@
// Grid aggregation walker. Action words enter on in_chan, one result word
// per action leaves on out_chan; grid size registers sit on an APB-style port.
// Actions: place root (code 5), spawn walker, walk step, read cell.
// Read, root and spawn words read the center cell and then finish; a walk
// step also reads the four neighbours, since the center and its four neighbours
// are read one per cycle through the single read port of the grid memory. A new
// word is accepted on the cycle after the previous result is loaded.
// The result sits in an output register; the next word is accepted while it
// waits, and only the finish of that next word waits for out_chan.ready.
// Reset: the grid size registers return to 64 x 64, the walker goes inactive
// at (0,0), and a clearing pass writes every grid entry to empty, one per
// cycle (GRID_COLS_MAX * GRID_ROWS_MAX entries, 4096 by default). in_chan is
// not ready during the pass; register writes are taken throughout.
// Depends on gaw_pkg, gaw_channels, gaw_ram, gaw_ctrl and gaw_datapath.
module grid_aggregation_walker_unit #(
  parameter int GRID_COLS_MAX = gaw_pkg::GRID_COLS_MAX_DEF,
  parameter int GRID_ROWS_MAX = gaw_pkg::GRID_ROWS_MAX_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  gaw_in_if.sink                      in_chan,
  gaw_out_if.source                   out_chan,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gaw_pkg::APB_AW-1:0]  paddr,
  input  logic [gaw_pkg::APB_DW-1:0]  pwdata,
  output logic [gaw_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  import gaw_pkg::*;

  dim_t     width_q, height_q;
  logic     cfg_wr;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // register writes complete in the access cycle
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_RESET;
      height_q <= DIM_RESET;
    end else if (cfg_wr) begin
      if (paddr[REG_SEL_BIT] == REG_HEIGHT) height_q <= pwdata[DIM_W-1:0];
      else                                   width_q  <= pwdata[DIM_W-1:0];
    end
  end

  // register read back
  assign prdata = (paddr[REG_SEL_BIT] == REG_WIDTH) ? APB_DW'(width_q) : APB_DW'(height_q);

  gaw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_chan.valid),
    .in_ready_o (in_chan.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  gaw_datapath #(
    .GRID_COLS_MAX (GRID_COLS_MAX),
    .GRID_ROWS_MAX (GRID_ROWS_MAX)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .in_action_i  (in_chan.action),
    .in_col_i     (in_chan.col),
    .in_row_i     (in_chan.row),
    .in_pick_i    (in_chan.pick),
    .width_cfg_i  (width_q),
    .height_cfg_i (height_q),
    .out_ready_i  (out_chan.ready),
    .out_valid_o  (out_chan.valid),
    .out_status_o (out_chan.status),
    .out_cell_o   (out_chan.cell_code),
    .out_wcol_o   (out_chan.walker_col),
    .out_wrow_o   (out_chan.walker_row)
  );

endmodule

@@ bench/tb_top.sv @@
// self-checking bench for grid_aggregation_walker_unit: action words in, result words out
// depends on gaw_pkg, gaw_channels and the walker rtl; grid size set over the apb port
module tb_top;
  import gaw_pkg::*;

  localparam int COLS = GRID_COLS_MAX_DEF;
  localparam int ROWS = GRID_ROWS_MAX_DEF;
  localparam int COL_LIMIT = (COLS < 64) ? COLS : 64;
  localparam int ROW_LIMIT = (ROWS < 64) ? ROWS : 64;
  localparam logic [APB_AW-1:0] ADDR_WIDTH  = '0;
  localparam logic [APB_AW-1:0] ADDR_HEIGHT = APB_AW'(1) << REG_SEL_BIT;

  typedef struct packed {
    action_e             act;
    coord_t              col;
    coord_t              row;
    logic [PICK_W-1:0]   pick;
  } action_word_t;

  typedef struct packed {
    status_e status;
    cell_t   code;
    coord_t  wcol;
    coord_t  wrow;
  } result_word_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic psel, penable, pwrite, pready;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata, prdata;

  gaw_in_if  in_if ();
  gaw_out_if out_if ();

  grid_aggregation_walker_unit i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_chan  (in_if),
    .out_chan (out_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // words waiting to be sent and results waiting to arrive
  action_word_t action_queue[$];
  result_word_t awaited_results[$];
  int error_count = 0;

  // shadow of the block: grid, walker and size registers
  cell_t  grid_model[COLS*ROWS];
  coord_t walker_col_m, walker_row_m;
  logic   walker_live_m;
  dim_t   width_reg_m, height_reg_m;

  function automatic int dim_limit(dim_t v, int lim);
    if (v < 1) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  function automatic int cell_idx(int c, int r);
    return r * COLS + c;
  endfunction

  function automatic int clip(int v, int hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // sender: bursts of words with random gaps between them
  logic in_fire = 1'b0;
  int burst_left = 1;
  int gap_left = 0;
  action_word_t next_word;

  always @(negedge clk_i) begin
    if (!in_if.valid || in_fire) begin
      if (gap_left > 0) begin
        gap_left--;
        in_if.valid <= 1'b0;
      end else if (action_queue.size() > 0) begin
        next_word = action_queue.pop_front();
        in_if.action <= next_word.act;
        in_if.col    <= next_word.col;
        in_if.row    <= next_word.row;
        in_if.pick   <= next_word.pick;
        in_if.valid  <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // receiver: ready follows a rotating stall mask
  logic [15:0] stall_mask = '1;
  logic [3:0]  stall_pos = '0;

  always @(negedge clk_i) begin
    out_if.ready <= stall_mask[stall_pos];
    stall_pos <= stall_pos + 4'd1;
  end

  // monitor: check results against the shadow, then predict accepted words
  int ew, eh, cx, cy, n_moves;
  cell_t nb_up, nb_rt, nb_dn, nb_lf, cell_now;
  nbr_e moves[4];
  status_e st_now;
  result_word_t want, got;

  always @(posedge clk_i) begin
    in_fire = 1'b0;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        got = '{status_e'(out_if.status), out_if.cell_code, out_if.walker_col,
                out_if.walker_row};
        if (awaited_results.size() == 0) begin
          error_count++;
          $display("%0t: result with none expected, expected nothing, got %h", $time, got);
        end else begin
          want = awaited_results.pop_front();
          check_field("status", want.status, got.status);
          check_field("cell_code", want.code, got.code);
          check_field("walker_col", want.wcol, got.wcol);
          check_field("walker_row", want.wrow, got.wrow);
        end
      end

      if (in_if.valid && in_if.ready) begin
        in_fire = 1'b1;
        ew = dim_limit(width_reg_m, COL_LIMIT);
        eh = dim_limit(height_reg_m, ROW_LIMIT);
        st_now = ST_DONE;
        cell_now = CELL_EMPTY;
        if (in_if.action == ACT_STEP) begin
          cx = walker_col_m;
          cy = walker_row_m;
          if (!walker_live_m) begin
            st_now = ST_NO_WALKER;
          end else if (cx >= ew || cy >= eh) begin
            // walker left behind by a shrunk grid
            walker_live_m = 1'b0;
            st_now = ST_RANGE;
          end else if (grid_model[cell_idx(cx, cy)] != CELL_EMPTY) begin
            // something was placed on the walker's cell: end without a write
            cell_now = grid_model[cell_idx(cx, cy)];
            walker_live_m = 1'b0;
            st_now = ST_ATTACHED;
          end else begin
            nb_up = (cy > 0) ? grid_model[cell_idx(cx, cy - 1)] : CELL_EMPTY;
            nb_rt = (cx + 1 < ew) ? grid_model[cell_idx(cx + 1, cy)] : CELL_EMPTY;
            nb_dn = (cy + 1 < eh) ? grid_model[cell_idx(cx, cy + 1)] : CELL_EMPTY;
            nb_lf = (cx > 0) ? grid_model[cell_idx(cx - 1, cy)] : CELL_EMPTY;
            if ((nb_up | nb_rt | nb_dn | nb_lf) != CELL_EMPTY) begin
              // stick toward the first occupied neighbour
              if (nb_up != CELL_EMPTY) cell_now = CELL_UP;
              else if (nb_rt != CELL_EMPTY) cell_now = CELL_RIGHT;
              else if (nb_dn != CELL_EMPTY) cell_now = CELL_DOWN;
              else cell_now = CELL_LEFT;
              grid_model[cell_idx(cx, cy)] = cell_now;
              walker_live_m = 1'b0;
              st_now = ST_ATTACHED;
            end else begin
              // list the legal moves, then take pick mod count
              n_moves = 0;
              if (cy + 1 < eh) begin moves[n_moves] = NBR_DN; n_moves++; end
              if (cx + 1 < ew) begin moves[n_moves] = NBR_RT; n_moves++; end
              if (cy > 0)      begin moves[n_moves] = NBR_UP; n_moves++; end
              if (cx > 0)      begin moves[n_moves] = NBR_LF; n_moves++; end
              if (n_moves == 0) begin
                walker_live_m = 1'b0;
                st_now = ST_STUCK;
              end else begin
                case (moves[int'(in_if.pick) % n_moves])
                  NBR_DN:  walker_row_m = coord_t'(cy + 1);
                  NBR_RT:  walker_col_m = coord_t'(cx + 1);
                  NBR_UP:  walker_row_m = coord_t'(cy - 1);
                  default: walker_col_m = coord_t'(cx - 1);
                endcase
                st_now = ST_MOVED;
              end
            end
          end
        end else if (in_if.col >= ew || in_if.row >= eh) begin
          st_now = ST_RANGE;
        end else if (in_if.action == ACT_ROOT) begin
          grid_model[cell_idx(in_if.col, in_if.row)] = CELL_ROOT;
          cell_now = CELL_ROOT;
        end else if (in_if.action == ACT_SPAWN) begin
          cell_now = grid_model[cell_idx(in_if.col, in_if.row)];
          if (cell_now != CELL_EMPTY) begin
            st_now = ST_REJECTED;
          end else begin
            walker_col_m = in_if.col;
            walker_row_m = in_if.row;
            walker_live_m = 1'b1;
          end
        end else begin
          cell_now = grid_model[cell_idx(in_if.col, in_if.row)];
        end
        awaited_results.push_back('{st_now, cell_now, walker_col_m, walker_row_m});
      end
    end
  end

  task automatic queue_action(action_e a, int c, int r, int p);
    action_queue.push_back('{a, coord_t'(c), coord_t'(r), PICK_W'(p)});
  endtask

  // apb write, then read back the register
  task automatic apb_write(logic [APB_AW-1:0] addr, dim_t value);
    logic [APB_DW-1:0] word;
    word = $urandom;
    word[DIM_W-1:0] = value;
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= word;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    check_field("prdata", {{(APB_DW-DIM_W){1'b0}}, value}, prdata);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_grid(int w, int h);
    apb_write(ADDR_WIDTH, dim_t'(w));
    apb_write(ADDR_HEIGHT, dim_t'(h));
    width_reg_m = dim_t'(w);
    height_reg_m = dim_t'(h);
  endtask

  // hold off until every word has gone and every result has come
  task automatic wait_drained();
    while (action_queue.size() != 0 || in_if.valid || awaited_results.size() != 0)
      @(negedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // one random phase: mostly particles released near a root, some noise
  task automatic run_phase(int w, int h, int budget);
    int gw, gh, pushed, anchor_c, anchor_r, n_steps;
    set_grid(w, h);
    gw = dim_limit(dim_t'(w), COL_LIMIT);
    gh = dim_limit(dim_t'(h), ROW_LIMIT);
    stall_mask = ($urandom_range(0, 2) == 0) ? '1 : 16'($urandom) | 16'd1;
    @(posedge clk_i);
    anchor_c = $urandom_range(0, gw - 1);
    anchor_r = $urandom_range(0, gh - 1);
    queue_action(ACT_ROOT, anchor_c, anchor_r, 0);
    pushed = 1;
    while (pushed < budget) begin
      if ($urandom_range(0, 9) == 0) begin
        queue_action(action_e'($urandom_range(0, 3)), $urandom_range(0, 63),
                     $urandom_range(0, 63), $urandom_range(0, 3));
        pushed++;
      end else begin
        if ($urandom_range(0, 3) == 0) begin
          anchor_c = $urandom_range(0, gw - 1);
          anchor_r = $urandom_range(0, gh - 1);
          queue_action(ACT_ROOT, anchor_c, anchor_r, $urandom_range(0, 3));
          pushed++;
        end
        queue_action(ACT_SPAWN, clip(anchor_c + $urandom_range(0, 8) - 4, gw - 1),
                     clip(anchor_r + $urandom_range(0, 8) - 4, gh - 1), $urandom_range(0, 3));
        n_steps = $urandom_range(1, 16);
        repeat (n_steps)
          queue_action(ACT_STEP, $urandom_range(0, 63), $urandom_range(0, 63),
                       $urandom_range(0, 3));
        pushed += n_steps + 1;
        if ($urandom_range(0, 2) == 0) begin
          queue_action(ACT_READ, $urandom_range(0, gw - 1), $urandom_range(0, gh - 1),
                       $urandom_range(0, 3));
          pushed++;
        end
      end
    end
    wait_drained();
  endtask

  // stimulus
  initial begin
    foreach (grid_model[i]) grid_model[i] = CELL_EMPTY;
    walker_col_m = '0;
    walker_row_m = '0;
    walker_live_m = 1'b0;
    width_reg_m = DIM_RESET;
    height_reg_m = DIM_RESET;
    in_if.valid = 1'b0;
    in_if.action = '0;
    in_if.col = '0;
    in_if.row = '0;
    in_if.pick = '0;
    out_if.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // full grid, oversize register value clamps to the maximum
    set_grid(127, 127);
    @(posedge clk_i);
    queue_action(ACT_READ, 63, 63, 0);
    queue_action(ACT_STEP, 0, 0, 0);              // no walker yet
    queue_action(ACT_ROOT, 63, 63, 0);
    queue_action(ACT_SPAWN, 63, 63, 0);           // occupied cell rejected
    queue_action(ACT_SPAWN, 62, 63, 0);
    queue_action(ACT_STEP, 0, 0, 1);              // sticks to the right
    queue_action(ACT_READ, 62, 63, 0);
    queue_action(ACT_ROOT, 3, 3, 0);
    queue_action(ACT_SPAWN, 3, 4, 0);
    queue_action(ACT_STEP, 0, 0, 2);              // sticks upward
    queue_action(ACT_ROOT, 5, 0, 0);
    queue_action(ACT_SPAWN, 6, 0, 0);
    queue_action(ACT_STEP, 0, 0, 3);              // sticks to the left, top edge
    queue_action(ACT_ROOT, 10, 11, 0);
    queue_action(ACT_SPAWN, 10, 10, 0);
    queue_action(ACT_STEP, 0, 0, 0);              // sticks downward
    queue_action(ACT_SPAWN, 20, 20, 0);
    queue_action(ACT_ROOT, 20, 20, 0);            // root dropped on the walker
    queue_action(ACT_STEP, 0, 0, 0);
    queue_action(ACT_ROOT, 0, 11, 0);
    queue_action(ACT_SPAWN, 63, 10, 0);
    queue_action(ACT_STEP, 0, 0, 3);              // right edge must not wrap to next row
    queue_action(ACT_SPAWN, 40, 40, 0);           // left live for the shrink below
    wait_drained();

    // zero register value clamps to a single cell
    set_grid(0, 0);
    stall_mask = 16'h5a5b;
    @(posedge clk_i);
    queue_action(ACT_STEP, 0, 0, 0);              // walker now outside the grid
    queue_action(ACT_READ, 63, 0, 0);
    queue_action(ACT_ROOT, 0, 63, 0);
    queue_action(ACT_SPAWN, 0, 0, 0);
    queue_action(ACT_STEP, 0, 0, 3);              // nowhere to go
    queue_action(ACT_READ, 0, 0, 0);
    wait_drained();

    run_phase(4, 4, 100);
    run_phase(2, 2, 40);
    run_phase(64, 64, 600);
    run_phase(1, 64, 60);
    run_phase(64, 1, 60);
    run_phase(8, 6, 200);
    run_phase(3, 5, 80);
    run_phase(16, 16, 400);
    run_phase(12, 9, 200);
    run_phase(40, 33, 110);

    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #6000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
